FILE: rtl/core/great_circle_distance_unit_assert.svh
// Assertion macros for the great-circle distance unit checker.
// Included by the checker file; needs nothing else.
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication
`define GCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define GCD_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

// next-cycle implication
`define GCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/gcd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, fixed-point constants and the CORDIC arctangent function.
// No dependencies.
package gcd_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int APPROX_STEPS    = 24;
   localparam int DEG_SHIFT       = 24 - ANGLE_FRAC_BITS;

   localparam int LAT_W    = 24;
   localparam int LON_W    = 25;
   localparam int DIST_W   = 23;
   localparam int RADIUS_W = 13;

   localparam int Q        = 30;   // fraction bits of radians and trig values
   localparam int ANG_W    = 36;   // degrees Q24, up to a few turns
   localparam int CW       = 34;   // CORDIC datapath
   localparam int TRIG_W   = 32;   // sin, cos and cos(arc) in Q30
   localparam int ARC_W    = 33;   // unsigned arc angle in Q30, up to pi
   localparam int OUT_FRAC = 8;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6371;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint DEG_HALF    = 180;
   localparam longint HALF_Q24    = DEG_HALF * 64'sd16777216;
   localparam longint FULL_Q24    = 2 * HALF_Q24;
   localparam longint QUARTER_Q24 = HALF_Q24 / 2;
   localparam longint DEG2RAD_Q30 = (PI_Q30 + DEG_HALF / 2) / DEG_HALF;

   // series term 1/(2k+1) of the arctangent expansion
   function automatic longint odd_div(int k, longint v);
      case (k)
         0:  return v;
         1:  return v / 3;
         2:  return v / 5;
         3:  return v / 7;
         4:  return v / 9;
         5:  return v / 11;
         6:  return v / 13;
         7:  return v / 15;
         8:  return v / 17;
         9:  return v / 19;
         10: return v / 21;
         11: return v / 23;
         12: return v / 25;
         13: return v / 27;
         14: return v / 29;
         15: return v / 31;
         16: return v / 33;
         17: return v / 35;
         18: return v / 37;
         default: return v / 39;
      endcase
   endfunction

   // atan(2^-i) in Q30
   function automatic longint atan_q30(int i);
      longint sum;
      longint term;
      int     sh;
      sum = 0;
      if (i == 0) return (PI_Q30 + 2) / 4;
      for (int k = 0; k < 20; k++) begin
         sh = i * (2 * k + 1);
         if (sh <= 40) begin
            term = odd_div(k, (64'sd1 <<< 40) >>> sh);
            sum  = k[0] ? sum - term : sum + term;
         end
      end
      return (sum + 512) >>> 10;
   endfunction

endpackage

FILE: rtl/core/gcd_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine of an angle in Q24 degrees: turn reduction, quadrant
// fold, radian scaling and a rotation CORDIC of one step per stage. Uses gcd_pkg.
module gcd_sincos #(
   parameter int STEPS = gcd_pkg::APPROX_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [gcd_pkg::ANG_W-1:0]  in_deg,
   output logic                              out_valid,
   output logic signed [gcd_pkg::TRIG_W-1:0] out_sin,
   output logic signed [gcd_pkg::TRIG_W-1:0] out_cos
);
   import gcd_pkg::*;

   localparam int FOLD_W = 32;
   localparam int D2R_W  = 26;
   localparam int PROD_W = FOLD_W + D2R_W;

   localparam logic signed [ANG_W-1:0]  FULL    = ANG_W'(FULL_Q24);
   localparam logic signed [ANG_W-1:0]  HALF    = ANG_W'(HALF_Q24);
   localparam logic signed [ANG_W-1:0]  QUARTER = ANG_W'(QUARTER_Q24);
   localparam logic signed [D2R_W-1:0] D2R     = D2R_W'(DEG2RAD_Q30);
   localparam logic signed [PROD_W-1:0] RND24  = PROD_W'(64'sd1 <<< 23);
   localparam logic signed [CW-1:0]     GAIN   = CW'(GAIN_Q30);

   logic signed [ANG_W-1:0]  cand [5];
   logic signed [ANG_W-1:0]  red_in, red_ff;
   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [FOLD_W-1:0] fold_in, fold_ff;
   logic                     neg_in, neg2_ff, neg3_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [CW-1:0]     z0_in;

   logic signed [CW-1:0] x_ff [STEPS+1];
   logic signed [CW-1:0] y_ff [STEPS+1];
   logic signed [CW-1:0] z_ff [STEPS+1];
   logic                 neg_ff [STEPS+1];
   logic                 vld_ff [STEPS+1];

   logic signed [TRIG_W-1:0] sin_ff, cos_ff;
   logic                     out_valid_ff;

   // bring the angle into [-180, 180) degrees
   always_comb begin
      cand[0] = in_deg;
      cand[1] = in_deg - FULL;
      cand[2] = in_deg + FULL;
      cand[3] = in_deg - (FULL <<< 1);
      cand[4] = in_deg + (FULL <<< 1);
      red_in  = cand[0];
      for (int j = 0; j < 5; j++) begin
         if (cand[j] >= -HALF && cand[j] < HALF) red_in = cand[j];
      end
   end

   // fold into [-90, 90] degrees, cosine changes sign
   always_comb begin
      neg_in  = 1'b0;
      fold_in = FOLD_W'(red_ff);
      if (red_ff > QUARTER) begin
         fold_in = FOLD_W'(HALF - red_ff);
         neg_in  = 1'b1;
      end else if (red_ff < -QUARTER) begin
         fold_in = FOLD_W'(-HALF - red_ff);
         neg_in  = 1'b1;
      end
   end

   assign prod_in = fold_ff * D2R;
   assign z0_in   = CW'((prod_ff + RND24) >>> 24);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         vld_ff[0] <= v3_ff;
      end
      red_ff    <= red_in;
      fold_ff   <= fold_in;
      neg2_ff   <= neg_in;
      prod_ff   <= prod_in;
      neg3_ff   <= neg2_ff;
      x_ff[0]   <= GAIN;
      y_ff[0]   <= '0;
      z_ff[0]   <= z0_in;
      neg_ff[0] <= neg3_ff;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
      logic signed [CW-1:0] x_in, y_in, z_in;

      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ATAN;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         x_ff[i+1]   <= x_in;
         y_ff[i+1]   <= y_in;
         z_ff[i+1]   <= z_in;
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[STEPS];
      end
      sin_ff <= TRIG_W'(y_ff[STEPS]);
      cos_ff <= neg_ff[STEPS] ? TRIG_W'(-x_ff[STEPS]) : TRIG_W'(x_ff[STEPS]);
   end

   assign out_valid = out_valid_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule

FILE: rtl/core/gcd_acos.sv
`timescale 1ns / 1ps
// Pipelined arc cosine in Q30: square root of 1 - c^2 one result bit per stage,
// then a vectoring CORDIC of one step per stage. Uses gcd_pkg.
module gcd_acos #(
   parameter int STEPS = gcd_pkg::APPROX_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [gcd_pkg::TRIG_W-1:0] in_cos,
   output logic                              out_valid,
   output logic        [gcd_pkg::ARC_W-1:0]  out_arc
);
   import gcd_pkg::*;

   localparam int AC_W       = Q + 1;
   localparam int RAD_W      = 2 * Q + 2;
   localparam int SQRT_STEPS = Q + 1;

   localparam logic [RAD_W-1:0]     ONE_SQ = RAD_W'(1) << (2 * Q);
   localparam logic signed [CW-1:0] PI_C   = CW'(PI_Q30);

   logic [AC_W-1:0]  ac_in, ac_ff, ac2_ff;
   logic             neg_in, neg1_ff, neg2_ff;
   logic             v1_ff, v2_ff;
   logic [RAD_W-1:0] sq_in, sq_ff;

   logic [RAD_W-1:0] rem_ff  [SQRT_STEPS+1];
   logic [RAD_W-1:0] root_ff [SQRT_STEPS+1];
   logic [AC_W-1:0]  sac_ff  [SQRT_STEPS+1];
   logic             sneg_ff [SQRT_STEPS+1];
   logic             svld_ff [SQRT_STEPS+1];

   logic signed [CW-1:0] x_ff [STEPS+1];
   logic signed [CW-1:0] y_ff [STEPS+1];
   logic signed [CW-1:0] z_ff [STEPS+1];
   logic                 neg_ff [STEPS+1];
   logic                 vld_ff [STEPS+1];

   logic signed [CW-1:0] zc, zs;
   logic [ARC_W-1:0]     arc_in, arc_ff;
   logic                 out_valid_ff;

   assign neg_in = in_cos[TRIG_W-1];
   assign ac_in  = neg_in ? AC_W'(-in_cos) : AC_W'(in_cos);
   assign sq_in  = RAD_W'(ac_ff) * RAD_W'(ac_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         svld_ff[0] <= 1'b0;
      end else begin
         v1_ff      <= in_valid;
         v2_ff      <= v1_ff;
         svld_ff[0] <= v2_ff;
      end
      ac_ff      <= ac_in;
      neg1_ff    <= neg_in;
      sq_ff      <= sq_in;
      ac2_ff     <= ac_ff;
      neg2_ff    <= neg1_ff;
      rem_ff[0]  <= ONE_SQ - sq_ff;
      root_ff[0] <= '0;
      sac_ff[0]  <= ac2_ff;
      sneg_ff[0] <= neg2_ff;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - j));
      logic [RAD_W-1:0] trial, rem_in, root_in;

      always_comb begin
         trial = root_ff[j] + BIT;
         if (rem_ff[j] >= trial) begin
            rem_in  = rem_ff[j] - trial;
            root_in = (root_ff[j] >> 1) + BIT;
         end else begin
            rem_in  = rem_ff[j];
            root_in = root_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            svld_ff[j+1] <= 1'b0;
         end else begin
            svld_ff[j+1] <= svld_ff[j];
         end
         rem_ff[j+1]  <= rem_in;
         root_ff[j+1] <= root_in;
         sac_ff[j+1]  <= sac_ff[j];
         sneg_ff[j+1] <= sneg_ff[j];
      end
   end

   // load the vector (|c|, sqrt(1 - c^2))
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= svld_ff[SQRT_STEPS];
      end
      x_ff[0]   <= CW'(sac_ff[SQRT_STEPS]);
      y_ff[0]   <= CW'(root_ff[SQRT_STEPS]);
      z_ff[0]   <= '0;
      neg_ff[0] <= sneg_ff[SQRT_STEPS];
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
      logic signed [CW-1:0] x_in, y_in, z_in;

      always_comb begin
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ATAN;
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         x_ff[i+1]   <= x_in;
         y_ff[i+1]   <= y_in;
         z_ff[i+1]   <= z_in;
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   // clamp at zero, mirror for a negative cosine
   always_comb begin
      zc     = (z_ff[STEPS] < 0) ? '0 : z_ff[STEPS];
      zs     = neg_ff[STEPS] ? PI_C - zc : zc;
      arc_in = (zs < 0) ? '0 : ARC_W'(zs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[STEPS];
      end
      arc_ff <= arc_in;
   end

   assign out_valid = out_valid_ff;
   assign out_arc   = arc_ff;

endmodule

FILE: rtl/core/great_circle_distance_unit.sv
`timescale 1ns / 1ps
// Top level of the great-circle distance unit: input staging, product and
// scaling stages, register port. Uses gcd_pkg, gcd_sincos and gcd_acos.
//
// Usage:
// - Drive two points (latitude, longitude in signed degrees, 16 fraction bits)
//   on the req_ ports and raise start; a transaction is taken on every rising
//   edge with start high and busy low. busy is high only during reset, so one
//   point pair enters per clock.
// - The distance comes out on rsp_distance with rsp_valid high for one
//   cycle, in radius units with 8 fraction bits. Results leave in input
//   order; the receiver cannot stall, and the pipeline never stops.
// - Latency is set by the three sine/cosine CORDIC lanes (STEPS stages), the
//   31-stage square root and the acos CORDIC (STEPS stages), one step each.
// - earth_radius sits at APB address 0; write it only while no transaction
//   is in flight. pready is always high.
// - Reset clears the radius to 6371 and drops every transaction in flight.
module great_circle_distance_unit #(
   parameter int STEPS = gcd_pkg::APPROX_STEPS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [gcd_pkg::LAT_W-1:0]   req_lat_a,
   input  logic signed [gcd_pkg::LON_W-1:0]   req_lon_a,
   input  logic signed [gcd_pkg::LAT_W-1:0]   req_lat_b,
   input  logic signed [gcd_pkg::LON_W-1:0]   req_lon_b,
   output logic                               rsp_valid,
   output logic        [gcd_pkg::DIST_W-1:0]  rsp_distance,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic        [2:0]                  paddr,
   input  logic        [31:0]                 pwdata,
   output logic        [31:0]                 prdata,
   output logic                               pready
);
   import gcd_pkg::*;

   localparam logic REG_EARTH_RADIUS = 1'b0;

   localparam int PP_W   = 2 * TRIG_W;
   localparam int SUM_W  = PP_W + 2;
   localparam int PROD_W = RADIUS_W + ARC_W;
   localparam int DSH    = Q - OUT_FRAC;
   localparam int RND_W  = PROD_W - DSH + 1;

   localparam logic signed [PP_W-1:0]  RND_PP  = PP_W'(64'sd1 <<< (Q - 1));
   localparam logic signed [SUM_W-1:0] RND_SUM = SUM_W'(64'sd1 <<< (Q - 1));
   localparam logic signed [SUM_W-1:0] ONE_S   = SUM_W'(64'sd1 <<< Q);
   localparam logic [PROD_W-1:0]       RND_D   = PROD_W'(1) << (DSH - 1);
   localparam logic [RND_W-1:0]        DMAX    = RND_W'({DIST_W{1'b1}});

   logic                  accept;
   logic [RADIUS_W-1:0]   radius_ff;

   logic signed [ANG_W-1:0] deg_a_in, deg_b_in, deg_d_in;
   logic signed [ANG_W-1:0] deg_a_ff, deg_b_ff, deg_d_ff;
   logic                    v0_ff;

   logic                     sc_valid, sc_valid_b, sc_valid_d;
   logic signed [TRIG_W-1:0] sa, ca, sb, cb, cd;

   logic signed [PP_W-1:0]   pcc_ff, pss_ff, pss2_ff, ptc_ff, pss3_ff;
   logic signed [TRIG_W-1:0] cd1_ff, cd2_ff, t_ff, c_ff;
   logic signed [TRIG_W-1:0] t_in, c_in;
   logic signed [SUM_W-1:0]  sum_in, sum_ff, cs;
   logic                     p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;

   logic               arc_valid;
   logic [ARC_W-1:0]   arc;
   logic [PROD_W-1:0]  dprod_ff;
   logic               d1_ff, rsp_valid_ff;
   logic [RND_W-1:0]   drnd;
   logic [DIST_W-1:0]  dist_in, dist_ff;

   assign busy   = reset;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_EARTH_RADIUS) begin
         radius_ff <= pwdata[RADIUS_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_EARTH_RADIUS) ? 32'(radius_ff) : '0;

   // widen angles to Q24 degrees
   assign deg_a_in = ANG_W'(req_lat_a) <<< DEG_SHIFT;
   assign deg_b_in = ANG_W'(req_lat_b) <<< DEG_SHIFT;
   assign deg_d_in = (ANG_W'(req_lon_b) - ANG_W'(req_lon_a)) <<< DEG_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
      end
      deg_a_ff <= deg_a_in;
      deg_b_ff <= deg_b_in;
      deg_d_ff <= deg_d_in;
   end

   gcd_sincos #(.STEPS(STEPS)) u_sincos_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_deg    (deg_a_ff),
      .out_valid (sc_valid),
      .out_sin   (sa),
      .out_cos   (ca)
   );

   gcd_sincos #(.STEPS(STEPS)) u_sincos_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_deg    (deg_b_ff),
      .out_valid (sc_valid_b),
      .out_sin   (sb),
      .out_cos   (cb)
   );

   gcd_sincos #(.STEPS(STEPS)) u_sincos_d (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_deg    (deg_d_ff),
      .out_valid (sc_valid_d),
      .out_sin   (),
      .out_cos   (cd)
   );

   // cos(arc) = sa*sb + round(ca*cb)*cd, rounded and clamped to [-1, 1]
   assign t_in   = TRIG_W'((pcc_ff + RND_PP) >>> Q);
   assign sum_in = SUM_W'(pss3_ff) + SUM_W'(ptc_ff) + RND_SUM;
   assign cs     = sum_ff >>> Q;

   always_comb begin
      if (cs > ONE_S) begin
         c_in = TRIG_W'(ONE_S);
      end else if (cs < -ONE_S) begin
         c_in = TRIG_W'(-ONE_S);
      end else begin
         c_in = TRIG_W'(cs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
         p3_ff <= 1'b0;
         p4_ff <= 1'b0;
         p5_ff <= 1'b0;
      end else begin
         p1_ff <= sc_valid && sc_valid_b && sc_valid_d;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
         p4_ff <= p3_ff;
         p5_ff <= p4_ff;
      end
      pcc_ff  <= ca * cb;
      pss_ff  <= sa * sb;
      cd1_ff  <= cd;
      t_ff    <= t_in;
      pss2_ff <= pss_ff;
      cd2_ff  <= cd1_ff;
      ptc_ff  <= t_ff * cd2_ff;
      pss3_ff <= pss2_ff;
      sum_ff  <= sum_in;
      c_ff    <= c_in;
   end

   gcd_acos #(.STEPS(STEPS)) u_acos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p5_ff),
      .in_cos    (c_ff),
      .out_valid (arc_valid),
      .out_arc   (arc)
   );

   // scale by the radius, round half up, saturate
   assign drnd    = RND_W'((dprod_ff + RND_D) >> DSH);
   assign dist_in = (drnd > DMAX) ? DIST_W'(DMAX) : DIST_W'(drnd);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         d1_ff        <= arc_valid;
         rsp_valid_ff <= d1_ff;
      end
      dprod_ff <= PROD_W'(radius_ff) * PROD_W'(arc);
      dist_ff  <= dist_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = dist_ff;

endmodule

FILE: rtl/core/gcd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for great_circle_distance_unit, bound to the top level.
// Uses gcd_pkg and great_circle_distance_unit_assert.svh.
`include "great_circle_distance_unit_assert.svh"

module gcd_checker #(
   parameter int STEPS = gcd_pkg::APPROX_STEPS
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import gcd_pkg::*;

   // input staging, the sin/cos lanes, five product stages, acos, two output stages
   localparam int LAT = 2 * STEPS + 49;

   // every accepted transaction yields exactly one result after the pipeline depth
   `GCD_ASSERT_DELAY(a_result_latency, clock, reset, start && !busy, LAT, rsp_valid, "result missing")
   `GCD_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, LAT), "spurious result")
   // reset flushes every transaction in flight
   `GCD_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid, "result after reset")

endmodule

bind great_circle_distance_unit gcd_checker #(.STEPS(STEPS)) u_gcd_checker (.*);

FILE: tb/sv/tb_great_circle_distance_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for great_circle_distance_unit: point pairs go in, and each distance
// is checked against a bit-exact fixed-point CORDIC predictor. Radius changes go over APB.
// Depends on gcd_pkg and the RTL of the unit.
module tb_great_circle_distance_unit;
   import gcd_pkg::*;

   localparam int  LATENCY   = 2 * APPROX_STEPS + 49;
   localparam int  LIMIT     = 400000;
   localparam int  N_RANDOM  = 2000;
   localparam int  RADIUS_IDX = 0;
   localparam longint DEG    = 64'sd65536;
   localparam longint ONE    = 64'sd1 << 30;

   logic clock, reset, start, busy, rsp_valid, psel, penable, pwrite, pready;
   logic signed [LAT_W-1:0] req_lat_a, req_lat_b;
   logic signed [LON_W-1:0] req_lon_a, req_lon_b;
   logic [DIST_W-1:0] rsp_distance;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   logic [RADIUS_W-1:0] radius_copy;
   logic [DIST_W-1:0]   distance_q[$];
   longint              arctan_tab[APPROX_STEPS];
   int                  errors;
   longint              cycles = 0;

   great_circle_distance_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // arctan(2^-i) in Q30 by the odd power series
   function automatic longint arctan_step(int i);
      longint sum, term;
      int sh;
      sum = 0;
      if (i == 0) return (PI_Q30 + 2) / 4;
      for (int k = 0; k < 64; k++) begin
         sh = i * (2 * k + 1);
         if (sh > 40) break;
         term = ((64'sd1 << 40) >>> sh) / (2 * k + 1);
         sum = (k % 2) ? sum - term : sum + term;
      end
      return (sum + 512) >>> 10;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
   endfunction

   task automatic rotate_angle(input longint deg24, output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      bit flip;
      r = deg24 % FULL_Q24;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (r < 0) r += FULL_Q24;
      if (r >= HALF_Q24) r -= FULL_Q24;
      // fold into [-90, 90] and flip cosine
      if (r > QUARTER_Q24) begin
         r = HALF_Q24 - r;
         flip = 1;
      end else if (r < -QUARTER_Q24) begin
         r = -HALF_Q24 - r;
         flip = 1;
      end
      z = round_shift(r * DEG2RAD_Q30, 24);
      for (int i = 0; i < APPROX_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_tab[i];
         end else begin
            x += dx; y -= dy; z += arctan_tab[i];
         end
      end
      c = flip ? -x : x;
      s = y;
   endtask

   function automatic longint int_sqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   task automatic predict_distance(input longint la, loa, lb, lob,
                                   output logic [DIST_W-1:0] distance_out);
      longint sa, ca, sb, cb, sd, cd, t, c, ac, x, y, z, dx, dy;
      logic [63:0] d;
      rotate_angle(la <<< DEG_SHIFT, sa, ca);
      rotate_angle(lb <<< DEG_SHIFT, sb, cb);
      rotate_angle((lob - loa) <<< DEG_SHIFT, sd, cd);
      t = round_shift(ca * cb, 30);
      c = round_shift(sa * sb + t * cd, 30);
      if (c > ONE) c = ONE;
      if (c < -ONE) c = -ONE;
      ac = c < 0 ? -c : c;
      x = ac;
      y = int_sqrt(ONE * ONE - ac * ac);
      z = 0;
      for (int i = 0; i < APPROX_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_tab[i];
         end else begin
            x -= dx; y += dy; z -= arctan_tab[i];
         end
      end
      if (z < 0) z = 0;
      if (c < 0) z = PI_Q30 - z;
      if (z < 0) z = 0;
      d = (64'(radius_copy) * z + (64'd1 << 21)) >> 22;
      distance_out = (d > 64'h7FFFFF) ? 23'h7FFFFF : d[DIST_W-1:0];
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (distance_q.size() == 0) begin
            $error("unexpected distance transaction: %0d", rsp_distance);
            errors++;
         end else begin
            if (rsp_distance !== distance_q[0]) begin
               $error("distance: expected %0d, actual %0d", distance_q[0], rsp_distance);
               errors++;
            end
            void'(distance_q.pop_front());
         end
      end
   end

   task automatic send_pair(input longint la, loa, lb, lob);
      logic [DIST_W-1:0] predicted;
      @(negedge clock);
      start = 1'b1;
      req_lat_a = la[LAT_W-1:0];
      req_lon_a = loa[LON_W-1:0];
      req_lat_b = lb[LAT_W-1:0];
      req_lon_b = lob[LON_W-1:0];
      do @(posedge clock); while (busy);
      predict_distance(longint'(req_lat_a), longint'(req_lon_a),
                       longint'(req_lat_b), longint'(req_lon_b), predicted);
      distance_q = {distance_q, predicted};
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      if (n == 0) return;
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (distance_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; paddr = 3'(4 * RADIUS_IDX); pwdata = 32'(value);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      radius_copy = value;
      // read back
      @(negedge clock);
      psel = 1'b1;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[RADIUS_W-1:0] !== value) begin
         $error("earth_radius: expected %0d, actual %0d", value, prdata[RADIUS_W-1:0]);
         errors++;
      end
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
   endtask

   function automatic longint rand_lat();
      if ($urandom_range(0, 9) == 0) return longint'($signed(24'($urandom)));
      return longint'($urandom_range(0, 11796480)) - 5898240;
   endfunction

   function automatic longint rand_lon();
      if ($urandom_range(0, 9) == 0) return longint'($signed(25'($urandom)));
      return longint'($urandom_range(0, 23592960)) - 11796480;
   endfunction

   task automatic test_special_points();
      send_pair(0, 0, 0, 0);                                // same point
      send_pair(0, 0, 0, 180 * DEG);                        // antipodal
      send_pair(90 * DEG, 0, -90 * DEG, 0);                 // pole to pole
      send_pair(90 * DEG, 0, 90 * DEG, 77 * DEG);
      send_pair(45 * DEG, 10 * DEG, 45 * DEG, 10 * DEG + 1); // nearly identical
      send_pair(5898240, 11796480, -5898240, -11796480);
      send_pair(-8388608, -16777216, 8388607, 16777215);    // beyond range
      send_pair(8388607, 16777215, -8388608, -16777216);
      send_pair(120 * DEG, 0, 30 * DEG, 200 * DEG);
      send_pair(-1, -1, 1, 1);
      send_pair(48 * DEG, 2 * DEG, 40 * DEG, -74 * DEG);
      send_pair(0, -179 * DEG, 0, 179 * DEG);               // wraps the dateline
   endtask

   task automatic test_radius_extremes();
      logic [RADIUS_W-1:0] settings[4] = '{13'd8191, 13'd0, 13'd1, 13'd4000};
      foreach (settings[k]) begin
         write_radius(settings[k]);
         send_pair(0, 0, 0, 180 * DEG);
         send_pair(0, 0, 0, 0);
         send_pair(30 * DEG, 40 * DEG, -20 * DEG, -100 * DEG);
         repeat (4) send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
         drain();
      end
   endtask

   task automatic test_random_pairs();
      longint la, loa;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 500 == 250) begin
            drain();
            write_radius(13'($urandom_range(1, 8191)));
         end
         if (n == 1000) drain();   // hold until every result is back
         if ($urandom_range(0, 7) == 0) begin
            la = rand_lat();
            loa = rand_lon();
            send_pair(la, loa, la + $urandom_range(0, 4) - 2, loa + $urandom_range(0, 4) - 2);
         end else begin
            send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
         end
         if (n % 300 < 200) idle_gap();
      end
   endtask

   initial begin
      errors = 0;
      radius_copy = RADIUS_RESET;
      for (int i = 0; i < APPROX_STEPS; i++) arctan_tab[i] = arctan_step(i);
      reset = 1'b1; start = 1'b0;
      req_lat_a = '0; req_lon_a = '0; req_lat_b = '0; req_lon_b = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_points();
      drain();
      test_radius_extremes();
      test_random_pairs();
      drain();

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/gcd_pkg.sv
rtl/core/gcd_sincos.sv
rtl/core/gcd_acos.sv
rtl/core/great_circle_distance_unit.sv
rtl/core/gcd_checker.sv
tb/sv/tb_great_circle_distance_unit.sv
